@@ rtl/core/sbad_pkg.sv @@
// ----------------------------------------------------------------------------
// sbad_pkg: shared types and constants for the system bus address decoder
// Route codes, access size codes, fixed decode addresses and the decision
// record that travels from the decode logic into the result stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sbad_pkg;

    localparam int ADDR_W    = 64;
    localparam int DATA_W    = 64;
    localparam int SLOT_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_LANES = 4;
    localparam int MAX_SLOTS = 4;

    localparam int DEF_RAM_BYTES = 524288;
    localparam int DEF_NUM_SLOTS = 4;

    localparam logic [ADDR_W-1:0] RAM_BASE       = 64'h0000_0000_fef0_0000;
    localparam logic [ADDR_W-1:0] WORD_HOLE_ADDR = 64'h0000_0000_fed3_00a4;
    localparam logic [ADDR_W-1:0] FED_MASK       = 64'h0000_0000_fff0_0000;
    localparam logic [ADDR_W-1:0] FED_MATCH      = 64'h0000_0000_fed0_0000;
    localparam logic [ADDR_W-1:0] FD_MASK        = 64'h0000_0000_ff00_0000;
    localparam logic [ADDR_W-1:0] FD_MATCH       = 64'h0000_0000_fd00_0000;

    // Low bit of a configuration index picks the end register of a slot.
    localparam int CFG_END_BIT = 0;

    typedef enum logic [1:0] {
        ROUTE_RAM    = 2'd0,
        ROUTE_HOLE   = 2'd1,
        ROUTE_DEVICE = 2'd2,
        ROUTE_FAULT  = 2'd3
    } route_t;

    typedef enum logic [1:0] {
        SIZE_BYTE   = 2'd0,
        SIZE_HALF   = 2'd1,
        SIZE_WORD   = 2'd2,
        SIZE_DOUBLE = 2'd3
    } size_t;

    typedef enum logic {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } opcode_t;

    typedef struct packed {
        route_t            route;
        logic [SLOT_W-1:0] slot;
        logic              ram_hit;
        logic              is_write;
        logic [1:0]        lane0;
        size_t             size;
    } dec_t;

    // True when byte k of an access of up to a word is part of the access; false for a double.
    function automatic logic lane_used(input logic [1:0] k, input size_t size);
        logic used;
        case (size)
            SIZE_BYTE: used = (k == 2'd0);
            SIZE_HALF: used = (k <= 2'd1);
            SIZE_WORD: used = 1'b1;
            default:   used = 1'b0;
        endcase
        return used;
    endfunction

endpackage

@@ rtl/core/system_bus_address_decoder_core.sv @@
// ----------------------------------------------------------------------------
// system_bus_address_decoder_core: bus access router
// Takes one access per clock while the result side keeps up (rsp_ready low
// stalls it) and returns one result per access. An access passes an input
// register, where holes, the scratch RAM window and the device slot ranges are
// all compared in parallel, and then a result register. The scratch RAM
// (RAM_BYTES, a multiple of four) is split into four byte-lane banks, so any
// access of up to four bytes, aligned or not and wrapping at the end of the
// store, is served by one access to each bank; the RAM read data comes out
// of the bank read registers alongside the result. RAM contents are undefined
// until written. The user must write slot ranges through cfg_we, cfg_index
// and cfg_data only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module system_bus_address_decoder_core
    import sbad_pkg::*;
#(
    parameter int RAM_BYTES = DEF_RAM_BYTES,
    parameter int NUM_SLOTS = DEF_NUM_SLOTS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  logic                 opcode,
    input  logic [1:0]           access_size,
    input  logic [ADDR_W-1:0]    address,
    input  logic [DATA_W-1:0]    write_data,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output logic [1:0]           route,
    output logic [SLOT_W-1:0]    device_slot,
    output logic [DATA_W-1:0]    read_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data
);

    localparam int OFF_W = $clog2(RAM_BYTES);
    localparam int ROW_W = OFF_W - 2;
    localparam int DEPTH = RAM_BYTES / NUM_LANES;

    logic              a_valid_reg;
    logic              a_valid_next;
    opcode_t           a_opcode_reg;
    size_t             a_size_reg;
    logic [ADDR_W-1:0] a_addr_reg;
    logic [DATA_W-1:0] a_wdata_reg;
    logic              b_valid_reg;
    logic              b_valid_next;
    dec_t              b_dec_reg;

    logic              accept;
    logic              advance;
    dec_t              dec;
    logic [ADDR_W-1:0] slot_start [NUM_SLOTS];
    logic [ADDR_W-1:0] slot_end   [NUM_SLOTS];
    logic [ROW_W-1:0]  bank_row   [NUM_LANES];
    logic              bank_use   [NUM_LANES];
    logic [7:0]        bank_wdata [NUM_LANES];
    logic [7:0]        bank_q     [NUM_LANES];
    logic              bank_en    [NUM_LANES];

    sbad_cfg_regs #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_cfg_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .slot_start (slot_start),
        .slot_end   (slot_end)
    );

    // The result register frees up when it is empty or being drained.
    assign advance   = a_valid_reg && (!b_valid_reg || rsp_ready);
    assign req_ready = !a_valid_reg || advance;
    assign accept    = req_valid && req_ready;

    assign a_valid_next = accept || (a_valid_reg && !advance);
    assign b_valid_next = advance || (b_valid_reg && !rsp_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_opcode_reg <= opcode_t'(opcode);
            a_size_reg   <= size_t'(access_size);
            a_addr_reg   <= address;
            a_wdata_reg  <= write_data;
        end
        if (advance)
        begin
            b_dec_reg <= dec;
        end
    end

    sbad_decode #(
        .RAM_BYTES (RAM_BYTES),
        .NUM_SLOTS (NUM_SLOTS),
        .OFF_W     (OFF_W),
        .ROW_W     (ROW_W)
    ) u_decode (
        .opcode      (a_opcode_reg),
        .access_size (a_size_reg),
        .address     (a_addr_reg),
        .write_data  (a_wdata_reg),
        .slot_start  (slot_start),
        .slot_end    (slot_end),
        .dec         (dec),
        .bank_row    (bank_row),
        .bank_use    (bank_use),
        .bank_wdata  (bank_wdata)
    );

    // Banks are touched only as an item moves into the result register, so
    // RAM accesses happen in item order.
    for (genvar b = 0; b < NUM_LANES; b++) begin : g_bank
        assign bank_en[b] = advance && dec.ram_hit && bank_use[b];

        sbad_ram_bank #(
            .DEPTH (DEPTH),
            .ROW_W (ROW_W)
        ) u_bank (
            .clk   (clk),
            .en    (bank_en[b]),
            .we    (dec.is_write),
            .row   (bank_row[b]),
            .wdata (bank_wdata[b]),
            .rdata (bank_q[b])
        );
    end

    always_comb
    begin
        logic [1:0] bank;
        read_data = '0;
        for (int k = 0; k < NUM_LANES; k++)
        begin
            bank = b_dec_reg.lane0 + 2'(k);
            if (b_dec_reg.ram_hit && !b_dec_reg.is_write
                && lane_used(2'(k), b_dec_reg.size))
            begin
                read_data[8*k +: 8] = bank_q[bank];
            end
        end
    end

    assign rsp_valid   = b_valid_reg;
    assign route       = b_dec_reg.route;
    assign device_slot = b_dec_reg.slot;

`ifndef SYNTH
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> a_valid_reg)
        else $error("accepted item did not reach the input register");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (route != ROUTE_DEVICE)) |-> (device_slot == '0))
        else $error("device slot set on a result that is not a device access");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (route != ROUTE_RAM)) |-> (read_data == '0))
        else $error("read data set on a result that is not a RAM access");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (read_data[DATA_W-1:32] == '0))
        else $error("read data wider than a word");
`endif

endmodule

@@ rtl/core/sbad_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// sbad_cfg_regs: device slot range registers
// Holds the first and last address of every device slot. Writes to slots
// that are not built in are ignored.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbad_cfg_regs
    import sbad_pkg::*;
#(
    parameter int NUM_SLOTS = DEF_NUM_SLOTS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    output logic [ADDR_W-1:0]    slot_start [NUM_SLOTS],
    output logic [ADDR_W-1:0]    slot_end   [NUM_SLOTS]
);

    logic [ADDR_W-1:0] start_reg [NUM_SLOTS];
    logic [ADDR_W-1:0] end_reg   [NUM_SLOTS];

    for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_slot
        logic hit;

        assign hit = cfg_we && (cfg_index[CFG_IDX_W-1:1] == SLOT_W'(i));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                start_reg[i] <= '1;
                end_reg[i]   <= '0;
            end
            else if (hit)
            begin
                if (cfg_index[CFG_END_BIT])
                begin
                    end_reg[i] <= cfg_data;
                end
                else
                begin
                    start_reg[i] <= cfg_data;
                end
            end
        end

        assign slot_start[i] = start_reg[i];
        assign slot_end[i]   = end_reg[i];
    end

endmodule

@@ rtl/core/sbad_decode.sv @@
// ----------------------------------------------------------------------------
// sbad_decode: routing decision for one access
// Checks the holes, the scratch RAM window and the device slots in priority
// order, and works out which row of each byte-lane bank the access touches.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbad_decode
    import sbad_pkg::*;
#(
    parameter int RAM_BYTES = DEF_RAM_BYTES,
    parameter int NUM_SLOTS = DEF_NUM_SLOTS,
    parameter int OFF_W     = $clog2(RAM_BYTES),
    parameter int ROW_W     = OFF_W - 2
)
(
    input  opcode_t           opcode,
    input  size_t             access_size,
    input  logic [ADDR_W-1:0] address,
    input  logic [DATA_W-1:0] write_data,
    input  logic [ADDR_W-1:0] slot_start [NUM_SLOTS],
    input  logic [ADDR_W-1:0] slot_end   [NUM_SLOTS],
    output dec_t              dec,
    output logic [ROW_W-1:0]  bank_row   [NUM_LANES],
    output logic              bank_use   [NUM_LANES],
    output logic [7:0]        bank_wdata [NUM_LANES]
);

    localparam logic [ADDR_W-1:0] RAM_LIMIT = RAM_BASE + ADDR_W'(RAM_BYTES);
    localparam logic [OFF_W:0]    RAM_SIZE  = (OFF_W+1)'(RAM_BYTES);

    logic              fd_window;
    logic              fed_window;
    logic              ram_window;
    logic              slot_found;
    logic [SLOT_W-1:0] slot_sel;
    logic [OFF_W-1:0]  off;
    logic [OFF_W-1:0]  idx_wrap [NUM_LANES];

    assign fd_window  = (address & FD_MASK) == FD_MATCH;
    assign fed_window = (address & FED_MASK) == FED_MATCH;
    assign ram_window = (address >= RAM_BASE) && (address < RAM_LIMIT);
    assign off        = address[OFF_W-1:0] - RAM_BASE[OFF_W-1:0];

    // Scan from the highest slot down so the lowest matching slot wins.
    always_comb
    begin
        slot_found = 1'b0;
        slot_sel   = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if ((slot_start[i] <= address) && (address <= slot_end[i]))
            begin
                slot_found = 1'b1;
                slot_sel   = SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        dec          = '0;
        dec.route    = ROUTE_FAULT;
        dec.is_write = (opcode == OP_WRITE);
        dec.lane0    = off[1:0];
        dec.size     = access_size;
        if ((access_size == SIZE_WORD) && (opcode == OP_READ)
            && ((address == WORD_HOLE_ADDR) || fd_window))
        begin
            dec.route = ROUTE_HOLE;
        end
        else if ((access_size == SIZE_WORD) && (opcode == OP_WRITE) && fed_window)
        begin
            dec.route = ROUTE_HOLE;
        end
        else if ((access_size != SIZE_DOUBLE) && ram_window)
        begin
            dec.route   = ROUTE_RAM;
            dec.ram_hit = 1'b1;
        end
        else if ((opcode == OP_WRITE) && fd_window
                 && ((access_size == SIZE_HALF) || (access_size == SIZE_WORD)))
        begin
            dec.route = ROUTE_HOLE;
        end
        else if (slot_found)
        begin
            dec.route = ROUTE_DEVICE;
            dec.slot  = slot_sel;
        end
    end

    // Byte offsets of the access; a run past the end wraps to the start.
    always_comb
    begin
        logic [OFF_W:0] sum;
        for (int k = 0; k < NUM_LANES; k++)
        begin
            sum = {1'b0, off} + (OFF_W+1)'(k);
            if (sum >= RAM_SIZE)
            begin
                sum = sum - RAM_SIZE;
            end
            idx_wrap[k] = sum[OFF_W-1:0];
        end
    end

    // Banks hold bytes by offset modulo four, so each bank sees one byte at most.
    always_comb
    begin
        logic [1:0] kb;
        for (int b = 0; b < NUM_LANES; b++)
        begin
            kb            = 2'(b) - off[1:0];
            bank_row[b]   = idx_wrap[kb][OFF_W-1:2];
            bank_use[b]   = lane_used(kb, access_size);
            bank_wdata[b] = write_data[{kb, 3'b000} +: 8];
        end
    end

endmodule

@@ rtl/core/sbad_ram_bank.sv @@
// ----------------------------------------------------------------------------
// sbad_ram_bank: one byte lane of the scratch RAM
// Single-port byte memory with a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbad_ram_bank
    import sbad_pkg::*;
#(
    parameter int DEPTH = DEF_RAM_BYTES / NUM_LANES,
    parameter int ROW_W = $clog2(DEPTH)
)
(
    input  logic             clk,
    input  logic             en,
    input  logic             we,
    input  logic [ROW_W-1:0] row,
    input  logic [7:0]       wdata,
    output logic [7:0]       rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[row] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[row];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule
